/* sv/msk_pkg.sv */
// msk_pkg: shared widths, reset values, register indexes and the
// controller/datapath command and status types of the microprice filter
// no dependencies
package msk_pkg;

  localparam int PRICE_W   = 32;
  localparam int SIZE_W    = 24;
  localparam int VAR_W     = 32;
  localparam int GAIN_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = 56;   // 32 x 24 multiplier result
  localparam int DIVD_W    = 64;   // divider dividend
  localparam int DIVS_W    = 32;   // divider divisor and quotient

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE    = 2'd1;

  // reset values, Q16.16
  localparam logic [VAR_W-1:0] PROCESS_NOISE_RST = 32'd655;
  localparam logic [VAR_W-1:0] MEAS_NOISE_RST    = 32'd6554;
  localparam logic [VAR_W-1:0] VAR_RST           = 32'd65536;

  // multiplier operand selection
  typedef logic [1:0] mul_sel_t;
  localparam mul_sel_t MUL_BS_AP = 2'd0;   // bid size * ask price
  localparam mul_sel_t MUL_AS_BP = 2'd1;   // ask size * bid price
  localparam mul_sel_t MUL_MAG_K = 2'd2;   // |micro - estimate| * gain
  localparam mul_sel_t MUL_KC_PP = 2'd3;   // (1 - gain) * predicted variance

  typedef struct packed {
    logic     capture;    // latch the input beat
    logic     mul_en;     // load product register
    mul_sel_t mul_sel;
    logic     ld_pp;      // predicted variance
    logic     ld_acc;     // first product into accumulator
    logic     ld_den;     // innovation variance
    logic     ld_mid;     // microprice from mid price
    logic     div_start;
    logic     div_k;      // divider operands: gain instead of microprice
    logic     ld_micro;   // microprice from divider
    logic     ld_k;       // gain from divider, or zero
    logic     ld_diff;    // innovation magnitude and sign
    logic     upd_est;
    logic     upd_var;
    logic     ld_out;
  } cmd_t;

  typedef struct packed {
    logic size_zero;
    logic den_zero;
    logic div_done;
  } sts_t;

endpackage

/* sv/msk_div.sv */
// msk_div: restoring divider, one quotient bit per cycle, 32 bits of quotient
// the upper half of the dividend must be below the divisor
// depends on msk_pkg
module msk_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [msk_pkg::DIVD_W-1:0]   dividend,
  input  logic [msk_pkg::DIVS_W-1:0]   divisor,
  output logic                         done,
  output logic [msk_pkg::DIVS_W-1:0]   quotient
);

  logic                        busy_r;
  logic                        done_r;
  logic [4:0]                  cnt_r;
  logic [msk_pkg::DIVS_W-1:0]  rem_r;
  logic [msk_pkg::DIVS_W-1:0]  quo_r;
  logic [msk_pkg::DIVS_W-1:0]  dsr_r;
  logic [msk_pkg::DIVS_W:0]    shifted;
  logic [msk_pkg::DIVS_W:0]    trial;

  assign shifted = {rem_r, quo_r[msk_pkg::DIVS_W-1]};
  assign trial   = shifted - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 5'd0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd31;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[msk_pkg::DIVD_W-1:msk_pkg::DIVS_W];
      quo_r <= dividend[msk_pkg::DIVS_W-1:0];
      dsr_r <= divisor;
    end else if (busy_r) begin
      if (!trial[msk_pkg::DIVS_W]) begin
        rem_r <= trial[msk_pkg::DIVS_W-1:0];
        quo_r <= {quo_r[msk_pkg::DIVS_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[msk_pkg::DIVS_W-1:0];
        quo_r <= {quo_r[msk_pkg::DIVS_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

`ifndef ASSERT_OFF
  a_no_restart : assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_idle : assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still iterating");
`endif

endmodule

/* sv/msk_dp.sv */
// msk_dp: datapath of the microprice filter: config and filter state, the
// shared 32x24 multiplier, the shared divider and the output registers
// depends on msk_pkg and msk_div
module msk_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [msk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [msk_pkg::VAR_W-1:0]       cfg_data,
  input  logic [msk_pkg::PRICE_W-1:0]     in_bid_price,
  input  logic [msk_pkg::SIZE_W-1:0]      in_bid_size,
  input  logic [msk_pkg::PRICE_W-1:0]     in_ask_price,
  input  logic [msk_pkg::SIZE_W-1:0]      in_ask_size,
  input  msk_pkg::cmd_t                   cmd,
  output msk_pkg::sts_t                   sts,
  output logic [msk_pkg::PRICE_W-1:0]     out_estimate,
  output logic [msk_pkg::GAIN_W-1:0]      out_gain
);

  logic [msk_pkg::VAR_W-1:0]    pn_r;
  logic [msk_pkg::VAR_W-1:0]    mn_r;
  logic [msk_pkg::PRICE_W-1:0]  est_r;
  logic [msk_pkg::VAR_W-1:0]    var_r;
  logic [msk_pkg::PRICE_W-1:0]  bp_r;
  logic [msk_pkg::SIZE_W-1:0]   bs_r;
  logic [msk_pkg::PRICE_W-1:0]  ap_r;
  logic [msk_pkg::SIZE_W-1:0]   as_r;
  logic [msk_pkg::PROD_W-1:0]   prod_r;
  logic [msk_pkg::PROD_W-1:0]   acc_r;
  logic [msk_pkg::VAR_W-1:0]    pp_r;
  logic [msk_pkg::VAR_W-1:0]    den_r;
  logic [msk_pkg::PRICE_W-1:0]  micro_r;
  logic [msk_pkg::GAIN_W-1:0]   k_r;
  logic [msk_pkg::PRICE_W-1:0]  mag_r;
  logic                         neg_r;
  logic [msk_pkg::PRICE_W-1:0]  est_o_r;
  logic [msk_pkg::GAIN_W-1:0]   gain_o_r;

  logic [msk_pkg::PRICE_W-1:0]  mul_a;
  logic [msk_pkg::SIZE_W-1:0]   mul_b;
  logic [msk_pkg::PROD_W-1:0]   prod_nxt;
  logic [msk_pkg::VAR_W:0]      pp_sum;
  logic [msk_pkg::VAR_W:0]      den_sum;
  logic [msk_pkg::SIZE_W:0]     size_sum;
  logic [57:0]                  num_sum;
  logic [msk_pkg::PRICE_W:0]    mid_sum;
  logic [msk_pkg::GAIN_W:0]     k_comp;
  logic [msk_pkg::PROD_W-1:0]   rnd;
  logic [msk_pkg::DIVD_W-1:0]   div_dividend;
  logic [msk_pkg::DIVS_W-1:0]   div_divisor;
  logic                         div_done;
  logic [msk_pkg::DIVS_W-1:0]   div_quot;
  logic [msk_pkg::GAIN_W-1:0]   k_nxt;
  logic [msk_pkg::PRICE_W-1:0]  est_nxt;

  // saturating variance sums
  assign pp_sum  = {1'b0, var_r} + {1'b0, pn_r};
  assign den_sum = {1'b0, pp_r} + {1'b0, mn_r};

  // microprice numerator with half the size sum for round half up
  assign size_sum = {1'b0, bs_r} + {1'b0, as_r};
  assign num_sum  = {2'b00, acc_r} + {2'b00, prod_r} + {34'd0, size_sum[msk_pkg::SIZE_W:1]};
  assign mid_sum  = {1'b0, bp_r} + {1'b0, ap_r} + 33'd1;

  assign k_comp = 17'h10000 - {1'b0, k_r};
  assign rnd    = prod_r + 56'd32768;

  always_comb begin
    case (cmd.mul_sel)
      msk_pkg::MUL_BS_AP: begin
        mul_a = ap_r;
        mul_b = bs_r;
      end
      msk_pkg::MUL_AS_BP: begin
        mul_a = bp_r;
        mul_b = as_r;
      end
      msk_pkg::MUL_MAG_K: begin
        mul_a = mag_r;
        mul_b = {8'd0, k_r};
      end
      msk_pkg::MUL_KC_PP: begin
        mul_a = pp_r;
        mul_b = {7'd0, k_comp};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = msk_pkg::PROD_W'(mul_a) * msk_pkg::PROD_W'(mul_b);

  assign div_dividend = cmd.div_k ? {16'd0, pp_r, 16'd0} : {6'd0, num_sum};
  assign div_divisor  = cmd.div_k ? den_r : {7'd0, size_sum};

  msk_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // gain reaching one is clamped, zero denominator gives zero gain
  always_comb begin
    if (den_r == '0) begin
      k_nxt = '0;
    end else if (div_quot[msk_pkg::DIVS_W-1:msk_pkg::GAIN_W] != '0) begin
      k_nxt = '1;
    end else begin
      k_nxt = div_quot[msk_pkg::GAIN_W-1:0];
    end
  end

  assign est_nxt = neg_r ? (est_r - rnd[47:16]) : (est_r + rnd[47:16]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pn_r  <= msk_pkg::PROCESS_NOISE_RST;
      mn_r  <= msk_pkg::MEAS_NOISE_RST;
      est_r <= '0;
      var_r <= msk_pkg::VAR_RST;
    end else begin
      if (cfg_we && (cfg_index == msk_pkg::CFG_PROCESS_NOISE)) begin
        pn_r <= cfg_data;
      end
      if (cfg_we && (cfg_index == msk_pkg::CFG_MEAS_NOISE)) begin
        mn_r <= cfg_data;
      end
      if (cmd.upd_est) begin
        est_r <= est_nxt;
      end
      if (cmd.upd_var) begin
        var_r <= rnd[47:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      bp_r <= in_bid_price;
      bs_r <= in_bid_size;
      ap_r <= in_ask_price;
      as_r <= in_ask_size;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.ld_acc) begin
      acc_r <= prod_r;
    end
    if (cmd.ld_pp) begin
      pp_r <= pp_sum[msk_pkg::VAR_W] ? '1 : pp_sum[msk_pkg::VAR_W-1:0];
    end
    if (cmd.ld_den) begin
      den_r <= den_sum[msk_pkg::VAR_W] ? '1 : den_sum[msk_pkg::VAR_W-1:0];
    end
    if (cmd.ld_mid) begin
      micro_r <= mid_sum[msk_pkg::PRICE_W:1];
    end else if (cmd.ld_micro) begin
      micro_r <= div_quot;
    end
    if (cmd.ld_k) begin
      k_r <= k_nxt;
    end
    if (cmd.ld_diff) begin
      neg_r <= micro_r < est_r;
      mag_r <= (micro_r < est_r) ? (est_r - micro_r) : (micro_r - est_r);
    end
    if (cmd.ld_out) begin
      est_o_r  <= est_r;
      gain_o_r <= k_r;
    end
  end

  assign sts.size_zero = (size_sum == '0);
  assign sts.den_zero  = (den_r == '0);
  assign sts.div_done  = div_done;

  assign out_estimate = est_o_r;
  assign out_gain     = gain_o_r;

endmodule

/* sv/msk_ctrl.sv */
// msk_ctrl: sequencer of the microprice filter, input and output handshakes
// drives the datapath through msk_pkg::cmd_t, reads msk_pkg::sts_t
// depends on msk_pkg
module msk_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_book_valid,
  output logic          out_valid,
  input  logic          out_stall,
  output msk_pkg::cmd_t cmd,
  input  msk_pkg::sts_t sts
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MULA = 4'd1;
  localparam logic [3:0] S_MULB = 4'd2;
  localparam logic [3:0] S_SUM  = 4'd3;
  localparam logic [3:0] S_DIV1 = 4'd4;
  localparam logic [3:0] S_KDIV = 4'd5;
  localparam logic [3:0] S_DIV2 = 4'd6;
  localparam logic [3:0] S_DIFF = 4'd7;
  localparam logic [3:0] S_MULC = 4'd8;
  localparam logic [3:0] S_MULD = 4'd9;
  localparam logic [3:0] S_UPDV = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_book_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_MULA;
        end
      end
      S_MULA: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = msk_pkg::MUL_BS_AP;
        cmd.ld_pp   = 1'b1;
        state_nxt   = S_MULB;
      end
      S_MULB: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = msk_pkg::MUL_AS_BP;
        cmd.ld_acc  = 1'b1;
        cmd.ld_den  = 1'b1;
        state_nxt   = S_SUM;
      end
      S_SUM: begin
        if (sts.size_zero) begin
          cmd.ld_mid = 1'b1;
          state_nxt  = S_KDIV;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV1;
        end
      end
      S_DIV1: begin
        if (sts.div_done) begin
          cmd.ld_micro = 1'b1;
          state_nxt    = S_KDIV;
        end
      end
      S_KDIV: begin
        if (sts.den_zero) begin
          cmd.ld_k  = 1'b1;
          state_nxt = S_DIFF;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_k     = 1'b1;
          state_nxt     = S_DIV2;
        end
      end
      S_DIV2: begin
        if (sts.div_done) begin
          cmd.ld_k  = 1'b1;
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.ld_diff = 1'b1;
        state_nxt   = S_MULC;
      end
      S_MULC: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = msk_pkg::MUL_MAG_K;
        state_nxt   = S_MULD;
      end
      S_MULD: begin
        cmd.upd_est = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = msk_pkg::MUL_KC_PP;
        state_nxt   = S_UPDV;
      end
      S_UPDV: begin
        cmd.upd_var = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_done_in_wait : assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == S_DIV1 || state_r == S_DIV2))
    else $error("divider result outside a wait state");

  a_book_starts : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_book_valid) |=> (state_r == S_MULA))
    else $error("accepted book beat did not start an update");

  a_out_held : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && out_stall) |=> (state_r == S_OUT && out_valid_r))
    else $error("result overwrote a beat still waiting");
`endif

endmodule

/* sv/microprice_scalar_kalman.sv */
// microprice_scalar_kalman: top level of the microprice scalar kalman filter
// instantiates msk_ctrl and msk_dp, uses msk_pkg
//
// Each input beat is a top-of-book snapshot. A beat with in_book_valid low
// is taken without leaving the idle state and gives no result. Otherwise the block forms the
// size-weighted microprice (mid price when both sizes are zero), runs one
// scalar kalman update and delivers the new Q24.8 estimate and Q0.16 gain
// as one output beat. The one shared restoring divider is used first for
// the microprice and then for the gain; with both sizes zero the first
// division is skipped, and with zero predicted variance and zero
// measurement noise the second is skipped. One item is worked on at a time;
// the next beat is accepted as soon as the result sits in the output
// register, even while that beat is still stalled. Variance sums saturate
// at 2^32-1 and the gain is clamped below one. Configuration writes are
// always ready and are meant to be made only while the block is idle.
module microprice_scalar_kalman (
  input  logic                            clk,
  input  logic                            rst_n,
  // input snapshot channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_book_valid,
  input  logic [msk_pkg::PRICE_W-1:0]     in_bid_price,
  input  logic [msk_pkg::SIZE_W-1:0]      in_bid_size,
  input  logic [msk_pkg::PRICE_W-1:0]     in_ask_price,
  input  logic [msk_pkg::SIZE_W-1:0]      in_ask_size,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [msk_pkg::PRICE_W-1:0]     out_estimate,
  output logic [msk_pkg::GAIN_W-1:0]      out_gain,
  // configuration writes: index 0 process noise, index 1 measurement noise
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [msk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [msk_pkg::VAR_W-1:0]       cfg_data
);

  msk_pkg::cmd_t cmd;
  msk_pkg::sts_t sts;
  logic          cfg_we;

  // registers are plain flops, a write is always taken
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // sequencer: handshakes and the step order of one update
  msk_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_book_valid (in_book_valid),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cmd           (cmd),
    .sts           (sts)
  );

  // datapath: filter state, multiplier, divider, output registers
  msk_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_bid_price (in_bid_price),
    .in_bid_size  (in_bid_size),
    .in_ask_price (in_ask_price),
    .in_ask_size  (in_ask_size),
    .cmd          (cmd),
    .sts          (sts),
    .out_estimate (out_estimate),
    .out_gain     (out_gain)
  );

endmodule

/* tb/microprice_scalar_kalman_test.sv */
// microprice_scalar_kalman_test: self-checking bench for the microprice kalman filter
// drives snapshot beats and register writes, predicts every update, checks each result beat
// depends on msk_pkg and microprice_scalar_kalman
module microprice_scalar_kalman_test;
  timeunit 1ns;
  timeprecision 1ps;

  // write to an index past the register list, must be dropped by the block
  localparam logic [msk_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 2'd2;
  // drain time after the queues empty, to cover an item still in flight
  localparam int DRAIN_CYCLES = 120;
  localparam int HOLD_CYCLES  = 400;
  localparam int PRINT_CAP    = 200;

  typedef struct packed {
    logic                        book_valid;
    logic [msk_pkg::PRICE_W-1:0] bid_price;
    logic [msk_pkg::SIZE_W-1:0]  bid_size;
    logic [msk_pkg::PRICE_W-1:0] ask_price;
    logic [msk_pkg::SIZE_W-1:0]  ask_size;
  } book_t;

  typedef struct packed {
    logic [msk_pkg::PRICE_W-1:0] estimate;
    logic [msk_pkg::GAIN_W-1:0]  gain;
  } filtered_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_book_valid = 1'b0;
  logic [msk_pkg::PRICE_W-1:0]   in_bid_price = '0;
  logic [msk_pkg::SIZE_W-1:0]    in_bid_size = '0;
  logic [msk_pkg::PRICE_W-1:0]   in_ask_price = '0;
  logic [msk_pkg::SIZE_W-1:0]    in_ask_size = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [msk_pkg::PRICE_W-1:0]   out_estimate;
  logic [msk_pkg::GAIN_W-1:0]    out_gain;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [msk_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [msk_pkg::VAR_W-1:0]     cfg_data = '0;

  // snapshots waiting to be sent; the head stays on the bus until its beat is taken
  book_t       snapshots[$];
  // filter outputs predicted for accepted snapshots, oldest first
  filtered_t   est_due[$];

  // predicted filter state and register copies
  logic [msk_pkg::PRICE_W-1:0] filt_estimate;
  logic [msk_pkg::VAR_W-1:0]   filt_variance;
  logic [msk_pkg::VAR_W-1:0]   q_noise;
  logic [msk_pkg::VAR_W-1:0]   r_noise;

  logic [msk_pkg::PRICE_W-1:0] walk_price;
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_idle_pct = 0;
  int unsigned        books_taken = 0;
  int unsigned        hold_from_beat = 0;
  int unsigned        hold_left = 0;
  logic               hold_done = 1'b0;
  int unsigned        errors = 0;

  microprice_scalar_kalman uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_book_valid (in_book_valid),
    .in_bid_price  (in_bid_price),
    .in_bid_size   (in_bid_size),
    .in_ask_price  (in_ask_price),
    .in_ask_size   (in_ask_size),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_estimate  (out_estimate),
    .out_gain      (out_gain),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // generous bound, several times the slowest legal run
  initial begin
    #20ms;
    $display("microprice_scalar_kalman_test: errors");
    $finish;
  end

  task automatic note_error(string what);
    errors++;
    // keep the log bounded if everything goes wrong at once
    if (errors <= PRINT_CAP) $display("mismatch @%0t: %s", $time, what);
  endtask

  function automatic logic [msk_pkg::VAR_W-1:0] sat_sum(logic [msk_pkg::VAR_W-1:0] a,
                                                        logic [msk_pkg::VAR_W-1:0] b);
    logic [msk_pkg::VAR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[msk_pkg::VAR_W] ? '1 : s[msk_pkg::VAR_W-1:0];
  endfunction

  // one kalman step on an accepted snapshot; a one-sided book leaves state alone
  function automatic void kalman_predict(book_t b);
    logic [63:0]                 size_sum;
    logic [63:0]                 weighted;
    logic [63:0]                 wide;
    logic [msk_pkg::PRICE_W-1:0] micro;
    logic [msk_pkg::VAR_W-1:0]   pp;
    logic [msk_pkg::VAR_W-1:0]   dd;
    logic [31:0]                 k;
    filtered_t                   r;
    if (!b.book_valid) return;
    size_sum = 64'(b.bid_size) + 64'(b.ask_size);
    if (size_sum == 64'd0) begin
      // no size on either side: plain mid, rounded up on the half
      micro = 32'((64'(b.bid_price) + 64'(b.ask_price) + 64'd1) >> 1);
    end else begin
      weighted = 64'(b.bid_size) * 64'(b.ask_price) + 64'(b.ask_size) * 64'(b.bid_price);
      micro = 32'((weighted + (size_sum >> 1)) / size_sum);
    end
    // predicted variance and innovation variance, both saturating
    pp = sat_sum(filt_variance, q_noise);
    dd = sat_sum(pp, r_noise);
    if (dd == '0) begin
      k = 32'd0;
    end else begin
      wide = {16'd0, pp, 16'd0} / 64'(dd);
      // gain of exactly one is clamped just below it
      k = (wide > 64'd65535) ? 32'd65535 : wide[31:0];
    end
    // move toward micro by a rounded fraction of the gap, never past it
    if (micro >= filt_estimate) begin
      wide = 64'(micro - filt_estimate) * 64'(k) + 64'd32768;
      filt_estimate = filt_estimate + wide[47:16];
    end else begin
      wide = 64'(filt_estimate - micro) * 64'(k) + 64'd32768;
      filt_estimate = filt_estimate - wide[47:16];
    end
    wide = (64'd65536 - 64'(k)) * 64'(pp) + 64'd32768;
    filt_variance = wide[47:16];
    r.estimate = filt_estimate;
    r.gain = k[15:0];
    est_due.push_back(r);
  endfunction

  // input driver: offer the queue head, hold it while stalled, idle at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        kalman_predict(snapshots.pop_front());
        books_taken <= books_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (snapshots.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid      <= 1'b1;
          in_book_valid <= snapshots[0].book_valid;
          in_bid_price  <= snapshots[0].bid_price;
          in_bid_size   <= snapshots[0].bid_size;
          in_ask_price  <= snapshots[0].ask_price;
          in_ask_size   <= snapshots[0].ask_size;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result-side stall: random, plus one long hold-off so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && hold_from_beat != 0 && books_taken >= hold_from_beat) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result monitor: every taken beat must match the oldest prediction
  always @(posedge clk) begin
    filtered_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (est_due.size() == 0) begin
        note_error($sformatf("unexpected beat estimate %0h gain %0h", out_estimate, out_gain));
      end else begin
        want = est_due.pop_front();
        if (out_estimate !== want.estimate)
          note_error($sformatf("estimate %0h, want %0h", out_estimate, want.estimate));
        if (out_gain !== want.gain)
          note_error($sformatf("gain %0h, want %0h", out_gain, want.gain));
      end
    end
  end

  // register write; the local copy follows once the beat is taken
  task automatic write_reg(logic [msk_pkg::CFG_IDX_W-1:0] idx, logic [msk_pkg::VAR_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      msk_pkg::CFG_PROCESS_NOISE: q_noise = data;
      msk_pkg::CFG_MEAS_NOISE:    r_noise = data;
      default: ;
    endcase
  endtask

  task automatic push_book(logic v, logic [msk_pkg::PRICE_W-1:0] bp,
                           logic [msk_pkg::SIZE_W-1:0] bs,
                           logic [msk_pkg::PRICE_W-1:0] ap,
                           logic [msk_pkg::SIZE_W-1:0] as_);
    book_t b;
    b.book_valid = v;
    b.bid_price  = bp;
    b.bid_size   = bs;
    b.ask_price  = ap;
    b.ask_size   = as_;
    snapshots.push_back(b);
  endtask

  // mostly a sane book around a wandering price, some raw noise, some empty sizes,
  // and some one-sided books that the block must skip
  function automatic book_t draw_snapshot();
    book_t       b;
    int unsigned pick;
    pick = $urandom_range(99);
    b.book_valid = 1'b1;
    b.bid_price  = $urandom;
    b.ask_price  = $urandom;
    b.bid_size   = 24'($urandom);
    b.ask_size   = 24'($urandom);
    if (pick < 62) begin
      walk_price  = walk_price + 32'($urandom_range(512)) - 32'd256;
      b.bid_price = walk_price;
      b.ask_price = walk_price + 32'($urandom_range(255));
      b.bid_size  = 24'($urandom_range(2000));
      b.ask_size  = 24'($urandom_range(2000));
    end else if (pick < 84) begin
      // full-range fields as drawn
    end else if (pick < 91) begin
      b.bid_size = '0;
      b.ask_size = '0;
      if (pick < 88) begin
        b.bid_price = walk_price;
        b.ask_price = walk_price + 32'($urandom_range(255));
      end
    end else begin
      b.book_valid = 1'b0;
    end
    return b;
  endfunction

  // queue random snapshots until n two-sided books are in
  task automatic queue_random(int unsigned n);
    book_t       b;
    int unsigned two_sided;
    two_sided = 0;
    while (two_sided < n) begin
      b = draw_snapshot();
      snapshots.push_back(b);
      if (b.book_valid) two_sided++;
    end
  endtask

  // wait until everything sent has come back, then let a skipped beat finish too
  task automatic settle();
    while (snapshots.size() != 0 || est_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    filt_estimate = '0;
    filt_variance = msk_pkg::VAR_RST;
    q_noise       = msk_pkg::PROCESS_NOISE_RST;
    r_noise       = msk_pkg::MEAS_NOISE_RST;
    walk_price    = 32'($urandom_range(32'h0100_0000, 32'h0010_0000));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // sender idles a third of the time, receiver about half
    send_idle_pct = 34;
    recv_idle_pct = 47;

    // directed part, reset register values
    push_book(1'b0, '1, '1, '1, '1);                      // one-sided, all ones, skipped
    push_book(1'b1, 32'd25600, 24'd10, 32'd25700, 24'd10);
    push_book(1'b1, 32'd1, '0, 32'd2, '0);                // mid price, half rounds up
    push_book(1'b1, '1, '0, '1, '0);                      // mid price at the top
    push_book(1'b1, 32'd25600, '0, 32'd25856, '1);        // all weight on bid price
    push_book(1'b1, 32'd25600, '1, 32'd25856, '0);        // all weight on ask price
    push_book(1'b1, '1, '1, '1, '1);                      // widest products
    push_book(1'b1, '0, 24'd1, '0, 24'd1);                // estimate pulled down
    push_book(1'b1, '0, '0, '0, '0);
    push_book(1'b1, 32'd0, 24'd1, 32'd1, 24'd2);          // 1/3 rounds down
    push_book(1'b1, 32'd0, 24'd1, 32'd2, 24'd2);          // 2/3 rounds up
    push_book(1'b1, 32'h0001_0100, 24'd7, 32'h0001_0000, 24'd3); // crossed book
    push_book(1'b0, '0, '0, '0, '0);
    push_book(1'b1, 32'hAAAA_AAAA, 24'h555555, 32'h5555_5555, 24'hAAAAAA);
    push_book(1'b1, 32'h5555_5555, 24'hAAAAAA, 32'hAAAA_AAAA, 24'h555555);
    push_book(1'b1, '1, 24'd1, '1, 24'd1);                // big step up
    push_book(1'b1, 32'd256, 24'd1, 32'd256, 24'd1);      // big step down
    push_book(1'b0, 32'd100, 24'd5, 32'd200, 24'd5);
    push_book(1'b1, 32'd25600, 24'd100, 32'd25601, 24'd1);
    push_book(1'b1, 32'd25600, 24'd1, 32'd25601, 24'd100);
    queue_random(270);
    settle();

    // smallest noise values: gain collapses quickly
    write_reg(msk_pkg::CFG_PROCESS_NOISE, '0);
    write_reg(msk_pkg::CFG_MEAS_NOISE, 32'd1);
    queue_random(270);
    settle();

    // roles swapped
    send_idle_pct = 47;
    recv_idle_pct = 34;

    // largest values: variance sums saturate and the gain hits its clamp
    write_reg(msk_pkg::CFG_PROCESS_NOISE, '1);
    write_reg(msk_pkg::CFG_MEAS_NOISE, '1);
    queue_random(270);
    settle();

    // a write past the register list, then arbitrary settings
    write_reg(CFG_NO_REG, $urandom);
    write_reg(msk_pkg::CFG_PROCESS_NOISE, 32'($urandom_range(32'h0004_0000)));
    write_reg(msk_pkg::CFG_MEAS_NOISE, $urandom);
    queue_random(270);
    settle();

    // no idling from here on
    send_idle_pct = 0;
    recv_idle_pct = 0;

    // no noise at all: variance drains to zero and then the gain is zero
    write_reg(msk_pkg::CFG_PROCESS_NOISE, '0);
    write_reg(msk_pkg::CFG_MEAS_NOISE, '0);
    queue_random(90);
    settle();

    // back to a live filter, with one long receiver hold-off early on
    write_reg(msk_pkg::CFG_PROCESS_NOISE, 32'd65536);
    write_reg(msk_pkg::CFG_MEAS_NOISE, 32'd655360);
    hold_from_beat = books_taken + 40;
    queue_random(450);
    settle();

    if (errors == 0) begin
      $display("microprice_scalar_kalman_test: clean");
    end else begin
      $display("microprice_scalar_kalman_test: errors");
    end
    $finish;
  end

endmodule
